### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the echo ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the ultrasonic echo ranger modules.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int TRIG_W    = 10;
  localparam int TIMEOUT_W = 16;
  localparam int REQ_W     = 2;
  localparam int CHAN_W    = 3;
  localparam int LEVEL_W   = 8;
  localparam int DIST_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_READ  = 2'd2
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE  = 2'd0,
    ST_RISED = 2'd1,
    ST_FELL  = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef enum logic {
    REG_TRIGGER_TICKS = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } reg_idx_t;

  localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd40000;
  localparam logic [DIST_W-1:0]    DIST_MAX      = 8'd255;

  // Width in ticks per centimeter. Division is a multiply by a rounded-up
  // reciprocal; the rounding error stays below one for all 16-bit widths.
  localparam int CM_DIVISOR  = 58;
  localparam int RECIP_SHIFT = 21;
  localparam logic [TIMEOUT_W-1:0] CM_RECIP =
    16'((2**RECIP_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR);
  localparam int PROD_W = 2 * TIMEOUT_W;
  localparam int QUO_W  = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic fire;
    logic tick;
    logic start;
    logic read;
    logic level;
  } chan_cmd_t;

  typedef struct packed {
    status_t              status;
    logic [TIMEOUT_W-1:0] captured;
    logic                 trig_on;
  } chan_view_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  trigger_levels;
    logic                result_valid;
    logic [CHAN_W-1:0]   result_channel;
    logic [DIST_W-1:0]   distance_cm;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

### src/uer_ifs.sv
// ----------------------------------------------------------------------------
// uer_ifs
// Valid/ready stream interfaces for the echo ranger request and response.
// ----------------------------------------------------------------------------
interface uer_req_if;
  import uer_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CHAN_W-1:0]  channel;
  logic [LEVEL_W-1:0] echo_levels;

  modport source (output valid, req_type, channel, echo_levels, input ready);
  modport sink (input valid, req_type, channel, echo_levels, output ready);
endinterface

interface uer_rsp_if;
  import uer_pkg::*;

  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  trigger_levels;
  logic                result_valid;
  logic [CHAN_W-1:0]   result_channel;
  logic [DIST_W-1:0]   distance_cm;
  logic [STATUS_W-1:0] status;

  modport source (output valid, trigger_levels, result_valid, result_channel,
                  distance_cm, status, input ready);
  modport sink (input valid, trigger_levels, result_valid, result_channel,
                distance_cm, status, output ready);
endinterface

### src/uer_channel.sv
// ----------------------------------------------------------------------------
// uer_channel
// State of one sensor channel: trigger countdown, echo edge timing, capture.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uer_channel (
  input  logic                           clk,
  input  logic                           rst,
  input  uer_pkg::chan_cmd_t             cmd,
  input  logic [uer_pkg::TRIG_W-1:0]     trigger_ticks,
  input  logic [uer_pkg::TIMEOUT_W-1:0]  timeout_ticks,
  output uer_pkg::chan_view_t            view
);
  import uer_pkg::*;

  status_t              status, status_next;
  logic                 echo_prev, echo_prev_next;
  logic                 armed, armed_next;
  logic [TRIG_W-1:0]    trig_left, trig_left_next;
  logic [TIMEOUT_W-1:0] echo_count, echo_count_next;
  logic [TIMEOUT_W-1:0] captured, captured_next;
  logic [TIMEOUT_W-1:0] count_upd;

  always_comb begin
    status_next     = status;
    echo_prev_next  = echo_prev;
    armed_next      = armed;
    trig_left_next  = trig_left;
    echo_count_next = echo_count;
    captured_next   = captured;
    count_upd       = echo_count;
    if (cmd.tick) begin
      echo_prev_next = cmd.level;
      if (trig_left != '0) begin
        trig_left_next = trig_left - TRIG_W'(1);
        if (trig_left == TRIG_W'(1)) begin
          armed_next = 1'b1;
        end
      end else if (armed) begin
        if (cmd.level && !echo_prev) begin
          status_next     = ST_RISED;
          echo_count_next = '0;
        end else begin
          if (status == ST_RISED) begin
            count_upd = (echo_count >= timeout_ticks) ? timeout_ticks
                                                      : echo_count + TIMEOUT_W'(1);
          end
          echo_count_next = count_upd;
          // A falling edge closes a pulse only if a rise was seen first.
          if (!cmd.level && echo_prev) begin
            if (status == ST_RISED) begin
              captured_next = count_upd;
              status_next   = ST_FELL;
              armed_next    = 1'b0;
            end else begin
              status_next = ST_ERROR;
            end
          end
        end
      end
    end else if (cmd.start) begin
      status_next     = ST_IDLE;
      echo_count_next = '0;
      trig_left_next  = trigger_ticks;
      armed_next      = (trigger_ticks == '0);
    end else if (cmd.read) begin
      armed_next     = 1'b0;
      trig_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status     <= ST_IDLE;
      echo_prev  <= 1'b0;
      armed      <= 1'b0;
      trig_left  <= '0;
      echo_count <= '0;
      captured   <= '0;
    end else if (cmd.fire) begin
      status     <= status_next;
      echo_prev  <= echo_prev_next;
      armed      <= armed_next;
      trig_left  <= trig_left_next;
      echo_count <= echo_count_next;
      captured   <= captured_next;
    end
  end

  assign view.status   = status;
  assign view.captured = captured;
  assign view.trig_on  = (trig_left_next != '0);

  `ASSERT_ALWAYS(a_not_armed_in_trigger, clk, rst, !(armed && (trig_left != '0)))
  `ASSERT_ALWAYS(a_fell_disarmed, clk, rst, !((status == ST_FELL) && armed))
  `ASSERT_NEXT(a_read_disarms, clk, rst, cmd.fire && cmd.read, !armed && (trig_left == '0))

endmodule

### src/uer_rsp_fifo.sv
// ----------------------------------------------------------------------------
// uer_rsp_fifo
// Two-entry result buffer that decouples the datapath from the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uer_rsp_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uer_pkg::rsp_t push_data,
  output logic          space,
  output logic          out_valid,
  output uer_pkg::rsp_t out_data,
  input  logic          out_ready
);
  import uer_pkg::*;

  rsp_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  // A full buffer still takes a new result in the cycle one is transferred out.
  assign space     = (count != 2'd2) || out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && (count == 2'd2) && !pop))
  `ASSERT_NEXT(a_push_visible, clk, rst, push, out_valid)
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= 2'd2)

endmodule

### src/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Multi-channel ultrasonic ranger: trigger pulses, echo timing, cm readout.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one item per transfer: a microsecond tick with the sampled
//   echo levels, a start on one channel, or a read of one channel.
//   response returns exactly one result per request, in order, with the
//   trigger levels after that item and, for a read, the distance and status.
//   The APB port holds trigger_ticks (offset 0) and timeout_ticks (offset 4);
//   write them only while no request is in flight.
// Timing:
//   A request is registered in the input register on transfer, processed
//   by the channel logic and the distance multiplier there, and its result
//   is written to the result buffer, which offers it on response. One
//   request per cycle is sustained while the buffer has space; all channels
//   update in parallel and the divide by 58 is a single reciprocal multiply.
// Reset clears every channel to idle, unarmed, with counters at zero, and
//   loads the register defaults (10 and 40000).
// Stall: a two-entry result buffer keeps taking requests while a result
//   waits; once both entries and the input register are held, request.ready
//   stays low until response.ready returns and a transfer frees an entry.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uer_pkg::PADDR_W-1:0]   paddr,
  input  logic [uer_pkg::PDATA_W-1:0]   pwdata,
  output logic [uer_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  uer_req_if.sink                       request,
  uer_rsp_if.source                     response
);
  import uer_pkg::*;

  localparam int OUT_CH = (CHANNELS < LEVEL_W) ? CHANNELS : LEVEL_W;

  // Configuration registers.
  logic [TRIG_W-1:0]    trigger_ticks;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  reg_idx_t             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIG_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TRIGGER_TICKS: trigger_ticks <= pwdata[TRIG_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRIGGER_TICKS: prdata = PDATA_W'(trigger_ticks);
      REG_TIMEOUT_TICKS: prdata = PDATA_W'(timeout_ticks);
      default:           prdata = '0;
    endcase
  end

  // Input register.
  logic               s1_valid;
  logic [REQ_W-1:0]   s1_type;
  logic [CHAN_W-1:0]  s1_channel;
  logic [LEVEL_W-1:0] s1_levels;
  logic               s1_fire;
  logic               fifo_space;

  assign s1_fire       = s1_valid && fifo_space;
  assign request.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_type    <= request.req_type;
      s1_channel <= request.channel;
      s1_levels  <= request.echo_levels;
    end
  end

  // Channel array.
  logic       is_tick, is_start, is_read, in_range;
  chan_cmd_t  cmd  [CHANNELS];
  chan_view_t view [CHANNELS];
  logic       lvl  [CHANNELS];

  assign is_tick  = (s1_type == REQ_TICK);
  assign is_start = (s1_type == REQ_START);
  assign is_read  = (s1_type == REQ_READ);
  assign in_range = (32'(s1_channel) < CHANNELS);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    if (i < LEVEL_W) begin : g_lvl
      assign lvl[i] = s1_levels[i];
    end else begin : g_nolvl
      assign lvl[i] = 1'b0;
    end

    assign cmd[i] = '{fire:  s1_fire,
                      tick:  is_tick,
                      start: is_start && (32'(s1_channel) == i),
                      read:  is_read && (32'(s1_channel) == i),
                      level: lvl[i]};

    uer_channel u_chan (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd[i]),
      .trigger_ticks(trigger_ticks),
      .timeout_ticks(timeout_ticks),
      .view         (view[i])
    );
  end

  // Read selection and distance conversion.
  status_t              sel_status;
  logic [TIMEOUT_W-1:0] sel_width;
  logic [PROD_W-1:0]    prod;
  logic [QUO_W-1:0]     quo;
  logic [DIST_W-1:0]    dist_fell;
  logic [DIST_W-1:0]    dist_sel;
  logic [LEVEL_W-1:0]   trig;
  rsp_t                 result;

  always_comb begin
    sel_status = ST_IDLE;
    sel_width  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(s1_channel) == i) begin
        sel_status = view[i].status;
        sel_width  = view[i].captured;
      end
    end
  end

  assign prod      = PROD_W'(sel_width) * PROD_W'(CM_RECIP);
  assign quo       = prod[PROD_W-1:RECIP_SHIFT];
  assign dist_fell = (quo > QUO_W'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];

  always_comb begin
    case (sel_status)
      ST_FELL:  dist_sel = dist_fell;
      ST_RISED: dist_sel = DIST_MAX;
      ST_ERROR: dist_sel = DIST_MAX;
      default:  dist_sel = '0;
    endcase
  end

  always_comb begin
    trig = '0;
    for (int i = 0; i < OUT_CH; i++) begin
      trig[i] = view[i].trig_on;
    end
  end

  always_comb begin
    result                = '0;
    result.trigger_levels = trig;
    if (is_read) begin
      result.result_valid   = 1'b1;
      result.result_channel = s1_channel;
      if (in_range) begin
        result.distance_cm = dist_sel;
        result.status      = sel_status;
      end
    end
  end

  // Result buffer.
  rsp_t out_data;

  uer_rsp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_fire),
    .push_data(result),
    .space    (fifo_space),
    .out_valid(response.valid),
    .out_data (out_data),
    .out_ready(response.ready)
  );

  assign response.trigger_levels = out_data.trigger_levels;
  assign response.result_valid   = out_data.result_valid;
  assign response.result_channel = out_data.result_channel;
  assign response.distance_cm    = out_data.distance_cm;
  assign response.status         = out_data.status;

endmodule
